>>> rtl/core/grbd_pkg.sv
package grbd_pkg;

  localparam int unsigned MAX_FIELD_BITS = 8;
  localparam int unsigned MAX_RESULTS    = 6;
  localparam int unsigned NUM_CFG        = 7;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned DIV_STEPS      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_XOFF    = 3'd2,
    CFG_YOFF    = 3'd3,
    CFG_ADVANCE = 3'd4,
    CFG_ZERO    = 3'd5,
    CFG_ONE     = 3'd6
  } cfg_idx_e;

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_W    = 9'b000000010,
    PH_H    = 9'b000000100,
    PH_XO   = 9'b000001000,
    PH_YO   = 9'b000010000,
    PH_ADV  = 9'b000100000,
    PH_ZERO = 9'b001000000,
    PH_ONE  = 9'b010000000,
    PH_REP  = 9'b100000000
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_STEP = 5'b00010,
    S_MUL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_DIV  = 5'b10000
  } seq_e;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_RUN    = 1'b1
  } kind_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        width_px;
    logic [7:0]        height_px;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic signed [7:0] advance;
    logic [7:0]        bg_count;
    logic [7:0]        fg_count;
    logic [7:0]        copies;
    logic [7:0]        start_col;
    logic [7:0]        start_row;
    logic              last;
  } res_t;

  function automatic logic [3:0] clamp_len(input logic [CFG_W-1:0] r);
    logic [3:0] l;
    l = r;
    if (r == '0) l = 4'd1;
    else if (r > CFG_W'(MAX_FIELD_BITS)) l = 4'(MAX_FIELD_BITS);
    return l;
  endfunction

endpackage

>>> rtl/core/grbd_if.sv
interface grbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       glyph_start;
  modport source (output valid, data_byte, glyph_start, input ready);
  modport sink   (input valid, data_byte, glyph_start, output ready);
endinterface

interface grbd_out_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        width_px;
  logic [7:0]        height_px;
  logic signed [7:0] offset_x;
  logic signed [7:0] offset_y;
  logic signed [7:0] advance;
  logic [7:0]        bg_count;
  logic [7:0]        fg_count;
  logic [7:0]        copies;
  logic [7:0]        start_col;
  logic [7:0]        start_row;
  logic              last;
  modport source (output valid, kind, width_px, height_px, offset_x, offset_y,
                  advance, bg_count, fg_count, copies, start_col, start_row, last,
                  input ready);
  modport sink   (input valid, kind, width_px, height_px, offset_x, offset_y,
                  advance, bg_count, fg_count, copies, start_col, start_row, last,
                  output ready);
endinterface

>>> rtl/core/grbd_div.sv
// restoring divider, one quotient bit per cycle
module grbd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         dividend_i,
  input  logic [7:0]          divisor_i,
  output grbd_pkg::div_stat_t stat_o,
  output logic [15:0]         quot_o,
  output logic [7:0]          rem_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [8:0]  trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[15]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 8'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(grbd_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a running division");
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && busy_q)) else $error("divider busy and done together");
`endif

endmodule

>>> rtl/core/glyph_rle_bitstream_decoder.sv
// Channel | Dir | Payload                                         | Accepted when
// in_if   | in  | data_byte[7:0], glyph_start                     | valid && ready
// out_if  | out | kind, header fields, run fields, start pos, last | valid && ready
// cfg     | in  | cfg_idx_i[2:0], cfg_data_i[3:0]                 | cfg_we_i
//
// A byte is taken in idle (a dropped byte stays there) and unpacked field by
// field in the step state; each run adds a multiply, an add and a wrap divide.
// A result waits in the output register; the sequencer stalls only when it
// needs to post another one while that register is still full.
// Reset (rst_ni, async low) returns to idle with the default field widths.
module glyph_rle_bitstream_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [grbd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [grbd_pkg::CFG_W-1:0]          cfg_data_i,
  grbd_in_if.sink                             in_if,
  grbd_out_if.source                          out_if
);

  grbd_pkg::seq_e   state_q, state_d;
  grbd_pkg::phase_e phase_q, phase_d;

  logic [grbd_pkg::CFG_W-1:0] cfg_q [grbd_pkg::NUM_CFG];

  logic [15:0] buf_q, buf_d;
  logic [4:0]  held_q, held_d;
  logic [7:0]  wid_q, wid_d, hgt_q, hgt_d, xoff_q, xoff_d, yoff_q, yoff_d;
  logic [7:0]  bg_q, bg_d, fg_q, fg_d, col_q, col_d, row_q, row_d;
  logic [6:0]  tally_q, tally_d;
  logic [15:0] pix_q, pix_d, area_q, area_d;
  logic [16:0] prod_q, prod_d;
  logic [2:0]  nres_q, nres_d;
  grbd_pkg::res_t res_q, res_d;
  logic        ovld_q, ovld_d;

  // shared field extractor
  logic [3:0]  need;
  logic [7:0]  fval;
  logic [7:0]  sval;
  logic [16:0] total;
  logic [15:0] total_sat;
  logic        out_free;
  logic        acc;

  // divider hookup
  logic                div_start;
  grbd_pkg::div_stat_t div_stat;
  logic [15:0]         div_quot;
  logic [7:0]          div_rem;

  grbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_sat),
    .divisor_i  (wid_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_free = !ovld_q || out_if.ready;
  assign acc      = in_if.valid && in_if.ready;

  always_comb begin
    unique case (phase_q)
      grbd_pkg::PH_W:    need = grbd_pkg::clamp_len(cfg_q[grbd_pkg::CFG_WIDTH]);
      grbd_pkg::PH_H:    need = grbd_pkg::clamp_len(cfg_q[grbd_pkg::CFG_HEIGHT]);
      grbd_pkg::PH_XO:   need = grbd_pkg::clamp_len(cfg_q[grbd_pkg::CFG_XOFF]);
      grbd_pkg::PH_YO:   need = grbd_pkg::clamp_len(cfg_q[grbd_pkg::CFG_YOFF]);
      grbd_pkg::PH_ADV:  need = grbd_pkg::clamp_len(cfg_q[grbd_pkg::CFG_ADVANCE]);
      grbd_pkg::PH_ZERO: need = grbd_pkg::clamp_len(cfg_q[grbd_pkg::CFG_ZERO]);
      grbd_pkg::PH_ONE:  need = grbd_pkg::clamp_len(cfg_q[grbd_pkg::CFG_ONE]);
      default:           need = 4'd1;
    endcase
    fval  = 8'(buf_q & ((16'd1 << need) - 16'd1));
    // raw value minus half range
    sval  = fval - (8'd1 << (need - 4'd1));
    total = {1'b0, pix_q} + prod_q;
    total_sat = total[16] ? 16'hFFFF : total[15:0];
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    buf_d   = buf_q;
    held_d  = held_q;
    wid_d   = wid_q;
    hgt_d   = hgt_q;
    xoff_d  = xoff_q;
    yoff_d  = yoff_q;
    bg_d    = bg_q;
    fg_d    = fg_q;
    col_d   = col_q;
    row_d   = row_q;
    tally_d = tally_q;
    pix_d   = pix_q;
    area_d  = area_q;
    prod_d  = prod_q;
    nres_d  = nres_q;
    res_d   = res_q;
    ovld_d  = ovld_q && !out_if.ready;
    div_start = 1'b0;

    unique case (state_q)
      grbd_pkg::S_IDLE: begin
        if (acc) begin
          nres_d = '0;
          if (in_if.glyph_start) begin
            phase_d = grbd_pkg::PH_W;
            wid_d = '0; hgt_d = '0; xoff_d = '0; yoff_d = '0;
            bg_d = '0; fg_d = '0; tally_d = '0; pix_d = '0;
            col_d = '0; row_d = '0;
            buf_d  = {8'd0, in_if.data_byte};
            held_d = 5'd8;
            state_d = grbd_pkg::S_STEP;
          end else if (phase_q != grbd_pkg::PH_IDLE) begin
            buf_d  = buf_q | ({8'd0, in_if.data_byte} << held_q);
            held_d = held_q + 5'd8;
            state_d = grbd_pkg::S_STEP;
          end
        end
      end

      grbd_pkg::S_STEP: begin
        if (nres_q == 3'(grbd_pkg::MAX_RESULTS) || held_q < {1'b0, need}) begin
          state_d = grbd_pkg::S_IDLE;
        end else if (phase_q != grbd_pkg::PH_ADV || out_free) begin
          buf_d  = buf_q >> need;
          held_d = held_q - {1'b0, need};
          unique case (phase_q)
            grbd_pkg::PH_W:  begin wid_d = fval;  phase_d = grbd_pkg::PH_H;  end
            grbd_pkg::PH_H:  begin hgt_d = fval;  phase_d = grbd_pkg::PH_XO; end
            grbd_pkg::PH_XO: begin xoff_d = sval; phase_d = grbd_pkg::PH_YO; end
            grbd_pkg::PH_YO: begin xoff_d = xoff_q; yoff_d = sval;
                                   phase_d = grbd_pkg::PH_ADV; end
            grbd_pkg::PH_ADV: begin
              res_d = '0;
              res_d.kind         = grbd_pkg::KIND_HEADER;
              res_d.width_px     = wid_q;
              res_d.height_px    = hgt_q;
              res_d.offset_x     = xoff_q;
              res_d.offset_y     = yoff_q;
              res_d.advance      = sval;
              ovld_d = 1'b1;
              nres_d = nres_q + 3'd1;
              pix_d = '0; col_d = '0; row_d = '0; tally_d = '0;
              area_d = {8'd0, wid_q} * {8'd0, hgt_q};
              if (wid_q == '0 || hgt_q == '0) begin
                res_d.last = 1'b1;
                phase_d = grbd_pkg::PH_IDLE;
                buf_d = '0; held_d = '0;
                state_d = grbd_pkg::S_IDLE;
              end else begin
                phase_d = grbd_pkg::PH_ZERO;
              end
            end
            grbd_pkg::PH_ZERO: begin bg_d = fval; phase_d = grbd_pkg::PH_ONE; end
            grbd_pkg::PH_ONE:  begin fg_d = fval; phase_d = grbd_pkg::PH_REP; end
            grbd_pkg::PH_REP: begin
              if (fval[0]) begin
                if (tally_q != 7'd127) tally_d = tally_q + 7'd1;
              end else begin
                state_d = grbd_pkg::S_MUL;
              end
            end
            default: state_d = grbd_pkg::S_IDLE;
          endcase
        end
      end

      grbd_pkg::S_MUL: begin
        prod_d  = {1'b0, 16'(({9'd0, tally_q} + 16'd1) * ({8'd0, bg_q} + {8'd0, fg_q}))};
        state_d = grbd_pkg::S_ADD;
      end

      grbd_pkg::S_ADD: begin
        if (out_free) begin
          res_d = '0;
          res_d.kind      = grbd_pkg::KIND_RUN;
          res_d.bg_count  = bg_q;
          res_d.fg_count  = fg_q;
          res_d.copies    = {1'b0, tally_q} + 8'd1;
          res_d.start_col = col_q;
          res_d.start_row = row_q;
          ovld_d  = 1'b1;
          nres_d  = nres_q + 3'd1;
          pix_d   = total_sat;
          tally_d = '0;
          if (total_sat >= area_q) begin
            res_d.last = 1'b1;
            phase_d = grbd_pkg::PH_IDLE;
            buf_d = '0; held_d = '0;
            state_d = grbd_pkg::S_IDLE;
          end else begin
            phase_d   = grbd_pkg::PH_ZERO;
            div_start = 1'b1;
            state_d   = grbd_pkg::S_DIV;
          end
        end
      end

      grbd_pkg::S_DIV: begin
        if (div_stat.done) begin
          col_d   = div_rem;
          row_d   = div_quot[7:0];
          state_d = grbd_pkg::S_STEP;
        end
      end

      default: state_d = grbd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grbd_pkg::S_IDLE;
      phase_q <= grbd_pkg::PH_IDLE;
      ovld_q  <= 1'b0;
      nres_q  <= '0;
      buf_q   <= '0;
      held_q  <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      xoff_q  <= '0;
      yoff_q  <= '0;
      bg_q    <= '0;
      fg_q    <= '0;
      tally_q <= '0;
      pix_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      cfg_q[grbd_pkg::CFG_WIDTH]   <= 4'd5;
      cfg_q[grbd_pkg::CFG_HEIGHT]  <= 4'd5;
      cfg_q[grbd_pkg::CFG_XOFF]    <= 4'd4;
      cfg_q[grbd_pkg::CFG_YOFF]    <= 4'd4;
      cfg_q[grbd_pkg::CFG_ADVANCE] <= 4'd5;
      cfg_q[grbd_pkg::CFG_ZERO]    <= 4'd4;
      cfg_q[grbd_pkg::CFG_ONE]     <= 4'd3;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ovld_q  <= ovld_d;
      nres_q  <= nres_d;
      buf_q   <= buf_d;
      held_q  <= held_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      xoff_q  <= xoff_d;
      yoff_q  <= yoff_d;
      bg_q    <= bg_d;
      fg_q    <= fg_d;
      tally_q <= tally_d;
      pix_q   <= pix_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i && cfg_idx_i < 3'(grbd_pkg::NUM_CFG)) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    area_q <= area_d;
    prod_q <= prod_d;
  end

  assign in_if.ready         = (state_q == grbd_pkg::S_IDLE);
  assign out_if.valid        = ovld_q;
  assign out_if.kind         = res_q.kind;
  assign out_if.width_px     = res_q.width_px;
  assign out_if.height_px    = res_q.height_px;
  assign out_if.offset_x     = res_q.offset_x;
  assign out_if.offset_y     = res_q.offset_y;
  assign out_if.advance      = res_q.advance;
  assign out_if.bg_count     = res_q.bg_count;
  assign out_if.fg_count     = res_q.fg_count;
  assign out_if.copies       = res_q.copies;
  assign out_if.start_col    = res_q.start_col;
  assign out_if.start_row    = res_q.start_row;
  assign out_if.last         = res_q.last;

`ifndef NO_ASSERTIONS
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == grbd_pkg::S_DIV) else $error("divider busy outside wrap");
  a_ready_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !div_stat.busy) else $error("ready during wrap divide");
  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == grbd_pkg::PH_IDLE |-> state_q == grbd_pkg::S_IDLE)
    else $error("sequencer running with no open glyph");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");
`endif

endmodule

>>> test/grbd_checker.sv
module grbd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [grbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [grbd_pkg::CFG_W-1:0]     cfg_data_i,
  grbd_in_if                             in_if,
  grbd_out_if                            out_if,
  output int                             fail_count_o,
  output int                             pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [grbd_pkg::CFG_W-1:0] field_len_q [grbd_pkg::NUM_CFG];

  logic [15:0]       bit_buf;
  logic [4:0]        bits_in_buf;
  grbd_pkg::phase_e  dec_phase;
  logic [7:0]        glyph_w, glyph_h, xoff_hold, yoff_hold;
  logic [7:0]        run_bg, run_fg;
  logic [6:0]        repeat_cnt;
  logic [15:0]       pixels_covered;
  logic [7:0]        run_col, run_row;

  grbd_pkg::res_t expected_runs_q[$];
  int   mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned eff_len(input logic [grbd_pkg::CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > grbd_pkg::MAX_FIELD_BITS) return grbd_pkg::MAX_FIELD_BITS;
    return raw;
  endfunction

  function automatic int unsigned bits_needed(input grbd_pkg::phase_e p);
    case (p)
      grbd_pkg::PH_W:    return eff_len(field_len_q[grbd_pkg::CFG_WIDTH]);
      grbd_pkg::PH_H:    return eff_len(field_len_q[grbd_pkg::CFG_HEIGHT]);
      grbd_pkg::PH_XO:   return eff_len(field_len_q[grbd_pkg::CFG_XOFF]);
      grbd_pkg::PH_YO:   return eff_len(field_len_q[grbd_pkg::CFG_YOFF]);
      grbd_pkg::PH_ADV:  return eff_len(field_len_q[grbd_pkg::CFG_ADVANCE]);
      grbd_pkg::PH_ZERO: return eff_len(field_len_q[grbd_pkg::CFG_ZERO]);
      grbd_pkg::PH_ONE:  return eff_len(field_len_q[grbd_pkg::CFG_ONE]);
      default: return 1;
    endcase
  endfunction

  function automatic logic [7:0] excess_code(input int unsigned raw, input int unsigned n);
    return 8'(raw - (1 << (n - 1)));
  endfunction

  task automatic drop_glyph();
    dec_phase      = grbd_pkg::PH_IDLE;
    bit_buf        = '0;
    bits_in_buf    = '0;
    glyph_w        = '0;
    glyph_h        = '0;
    xoff_hold      = '0;
    yoff_hold      = '0;
    run_bg         = '0;
    run_fg         = '0;
    repeat_cnt     = '0;
    pixels_covered = '0;
    run_col        = '0;
    run_row        = '0;
  endtask

  task automatic go_idle();
    dec_phase   = grbd_pkg::PH_IDLE;
    bit_buf     = '0;
    bits_in_buf = '0;
  endtask

  // Consume one stream byte, queue every result it completes.
  task automatic decode_byte(input logic [7:0] data, input logic start);
    int unsigned need, val, copies, total, area, n;
    grbd_pkg::res_t r;
    if (start) begin
      drop_glyph();
      dec_phase = grbd_pkg::PH_W;
    end
    if (dec_phase == grbd_pkg::PH_IDLE) return;
    bit_buf     = bit_buf | (16'(data) << bits_in_buf);
    bits_in_buf = bits_in_buf + 5'd8;
    n = 0;
    while (n < grbd_pkg::MAX_RESULTS && dec_phase != grbd_pkg::PH_IDLE) begin
      need = bits_needed(dec_phase);
      if (bits_in_buf < need) break;
      val         = bit_buf & ((1 << need) - 1);
      bit_buf     = bit_buf >> need;
      bits_in_buf = bits_in_buf - 5'(need);
      case (dec_phase)
        grbd_pkg::PH_W: begin
          glyph_w = 8'(val);
          dec_phase = grbd_pkg::PH_H;
        end
        grbd_pkg::PH_H: begin
          glyph_h = 8'(val);
          dec_phase = grbd_pkg::PH_XO;
        end
        grbd_pkg::PH_XO: begin
          xoff_hold = excess_code(val, need);
          dec_phase = grbd_pkg::PH_YO;
        end
        grbd_pkg::PH_YO: begin
          yoff_hold = excess_code(val, need);
          dec_phase = grbd_pkg::PH_ADV;
        end
        grbd_pkg::PH_ADV: begin
          r = '0;
          r.kind         = grbd_pkg::KIND_HEADER;
          r.width_px     = glyph_w;
          r.height_px    = glyph_h;
          r.offset_x     = xoff_hold;
          r.offset_y     = yoff_hold;
          r.advance      = excess_code(val, need);
          pixels_covered = '0;
          run_col        = '0;
          run_row        = '0;
          repeat_cnt     = '0;
          if (glyph_w == 0 || glyph_h == 0) begin
            r.last = 1'b1;
            go_idle();
          end else begin
            dec_phase = grbd_pkg::PH_ZERO;
          end
          expected_runs_q.push_back(r);
          n++;
        end
        grbd_pkg::PH_ZERO: begin
          run_bg = 8'(val);
          dec_phase = grbd_pkg::PH_ONE;
        end
        grbd_pkg::PH_ONE: begin
          run_fg = 8'(val);
          dec_phase = grbd_pkg::PH_REP;
        end
        default: begin
          if (val != 0) begin
            if (repeat_cnt < 7'd127) repeat_cnt++;
          end else begin
            copies = repeat_cnt + 1;
            total  = pixels_covered + copies * (run_bg + run_fg);
            area   = glyph_w * glyph_h;
            r = '0;
            r.kind      = grbd_pkg::KIND_RUN;
            r.bg_count  = run_bg;
            r.fg_count  = run_fg;
            r.copies    = 8'(copies);
            r.start_col = run_col;
            r.start_row = run_row;
            if (total > 16'hFFFF) total = 16'hFFFF;
            pixels_covered = 16'(total);
            run_col    = 8'(total % glyph_w);
            run_row    = 8'(total / glyph_w);
            repeat_cnt = '0;
            if (total >= area) begin
              r.last = 1'b1;
              go_idle();
            end else begin
              dec_phase = grbd_pkg::PH_ZERO;
            end
            expected_runs_q.push_back(r);
            n++;
          end
        end
      endcase
    end
  endtask

  task automatic check_result();
    grbd_pkg::res_t got, exp_r;
    got.kind         = out_if.kind;
    got.width_px     = out_if.width_px;
    got.height_px    = out_if.height_px;
    got.offset_x     = out_if.offset_x;
    got.offset_y     = out_if.offset_y;
    got.advance      = out_if.advance;
    got.bg_count     = out_if.bg_count;
    got.fg_count     = out_if.fg_count;
    got.copies       = out_if.copies;
    got.start_col    = out_if.start_col;
    got.start_row    = out_if.start_row;
    got.last         = out_if.last;
    if (expected_runs_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: unexpected result %p", $realtime, got);
      return;
    end
    exp_r = expected_runs_q.pop_front();
    if (got.kind !== exp_r.kind || got.width_px !== exp_r.width_px ||
        got.height_px !== exp_r.height_px || got.offset_x !== exp_r.offset_x ||
        got.offset_y !== exp_r.offset_y || got.advance !== exp_r.advance ||
        got.bg_count !== exp_r.bg_count || got.fg_count !== exp_r.fg_count ||
        got.copies !== exp_r.copies || got.start_col !== exp_r.start_col ||
        got.start_row !== exp_r.start_row || got.last !== exp_r.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch\n  exp %p\n  got %p", $realtime, exp_r, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_len_q[grbd_pkg::CFG_WIDTH]   = 4'd5;
      field_len_q[grbd_pkg::CFG_HEIGHT]  = 4'd5;
      field_len_q[grbd_pkg::CFG_XOFF]    = 4'd4;
      field_len_q[grbd_pkg::CFG_YOFF]    = 4'd4;
      field_len_q[grbd_pkg::CFG_ADVANCE] = 4'd5;
      field_len_q[grbd_pkg::CFG_ZERO]    = 4'd4;
      field_len_q[grbd_pkg::CFG_ONE]     = 4'd3;
      drop_glyph();
      expected_runs_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (in_if.valid && in_if.ready) decode_byte(in_if.data_byte, in_if.glyph_start);
      if (cfg_we_i && cfg_idx_i < grbd_pkg::NUM_CFG) field_len_q[cfg_idx_i] = cfg_data_i;
    end
    pending_o <= expected_runs_q.size();
  end

endmodule

>>> test/tb_glyph_rle_bitstream_decoder.sv
module tb_glyph_rle_bitstream_decoder;

  timeunit 1ns;
  timeprecision 1ps;

  // glyph shapes the stream builder can make
  localparam int GLYPH_PLAIN       = 0;
  localparam int GLYPH_EMPTY_RUN   = 1;  // first run covers no pixels
  localparam int GLYPH_LONG_REPEAT = 2;  // first run repeats past saturation
  // header offset/advance raw values
  localparam int HDR_RANDOM = 0;
  localparam int HDR_LOW    = 1;
  localparam int HDR_HIGH   = 2;

  localparam int ITEMS_PER_STEP = 52;  // six config steps, ~310 items
  localparam int SETTLE_CYCLES  = 200;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [grbd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [grbd_pkg::CFG_W-1:0]     cfg_data_i;

  int fail_count;
  int results_pending;
  int items_sent = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  // mirror of what was written, used to lay out the stream
  logic [grbd_pkg::CFG_W-1:0] cfg_shadow [grbd_pkg::NUM_CFG];

  grbd_in_if  in_if ();
  grbd_out_if out_if ();

  glyph_rle_bitstream_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  grbd_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_if        (in_if),
    .out_if       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  always #5 clk_i = ~clk_i;

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int field_bits(input logic [grbd_pkg::CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > grbd_pkg::MAX_FIELD_BITS) return grbd_pkg::MAX_FIELD_BITS;
    return raw;
  endfunction

  // Hand one item to the block; gaps before it follow the sender idle rate.
  task automatic put_byte(input logic [7:0] data, input logic start);
    if ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= data;
    in_if.glyph_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // Writes keep the enable high across all registers, then drop it.
  task automatic write_cfg(input logic [grbd_pkg::CFG_W-1:0] vals [grbd_pkg::NUM_CFG]);
    for (int i = 0; i < grbd_pkg::NUM_CFG; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= grbd_pkg::cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      cfg_shadow[i] = vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_field(ref bit q[$], input int val, input int n);
    for (int i = 0; i < n; i++) q.push_back(val[i]);
  endtask

  // Build one glyph bitstream from the current field lengths and send it.
  // may_cut lets a random glyph stop mid-stream (the next start recovers).
  task automatic send_glyph(input int w, input int h, input int hdr_sel, input int shape,
                            input bit may_cut);
    bit   stream[$];
    int   len [grbd_pkg::NUM_CFG];
    int   aw, ah, area, covered, runs, bg, fg, rep, nbytes;
    logic [7:0] b;
    for (int i = 0; i < grbd_pkg::NUM_CFG; i++) len[i] = field_bits(cfg_shadow[i]);
    aw = w & ((1 << len[grbd_pkg::CFG_WIDTH]) - 1);
    ah = h & ((1 << len[grbd_pkg::CFG_HEIGHT]) - 1);
    push_field(stream, aw, len[grbd_pkg::CFG_WIDTH]);
    push_field(stream, ah, len[grbd_pkg::CFG_HEIGHT]);
    for (int k = grbd_pkg::CFG_XOFF; k <= grbd_pkg::CFG_ADVANCE; k++) begin
      case (hdr_sel)
        HDR_LOW:  push_field(stream, 0, len[k]);
        HDR_HIGH: push_field(stream, 255, len[k]);
        default:  push_field(stream, $urandom, len[k]);
      endcase
    end
    area    = aw * ah;
    covered = 0;
    runs    = 0;
    while (covered < area) begin
      bg  = $urandom & ((1 << len[grbd_pkg::CFG_ZERO]) - 1);
      fg  = $urandom & ((1 << len[grbd_pkg::CFG_ONE]) - 1);
      rep = ($urandom_range(99) < 5) ? $urandom_range(120, 135) : $urandom_range(0, 3);
      if (runs == 0 && shape == GLYPH_EMPTY_RUN) begin
        bg = 0;
        fg = 0;
      end
      if (runs == 0 && shape == GLYPH_LONG_REPEAT) begin
        bg  = 0;
        fg  = 1;
        rep = 130;
      end
      if (runs >= 8) begin
        // wind up quickly
        fg  = (1 << len[grbd_pkg::CFG_ONE]) - 1;
        rep = $urandom_range(3, 6);
      end
      push_field(stream, bg, len[grbd_pkg::CFG_ZERO]);
      push_field(stream, fg, len[grbd_pkg::CFG_ONE]);
      for (int i = 0; i < rep; i++) stream.push_back(1'b1);
      stream.push_back(1'b0);
      covered += ((rep > 127) ? 128 : rep + 1) * (bg + fg);
      runs++;
    end
    while (stream.size() % 8 != 0) stream.push_back(1'($urandom_range(1)));
    nbytes = stream.size() / 8;
    if (may_cut && $urandom_range(99) < 8) nbytes = $urandom_range(1, nbytes);
    for (int i = 0; i < nbytes; i++) begin
      for (int j = 0; j < 8; j++) b[j] = stream[8 * i + j];
      put_byte(b, i == 0);
    end
  endtask

  function automatic int pick_size();
    if ($urandom_range(99) < 8) return 0;
    return $urandom_range(1, 7);
  endfunction

  initial begin
    logic [grbd_pkg::CFG_W-1:0] setting [grbd_pkg::NUM_CFG];
    int step_goal;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = grbd_pkg::CFG_WIDTH;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.glyph_start = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int step = 0; step < 6; step++) begin
      // idle pattern changes every second step
      case (step / 2)
        0: begin in_idle_pct = 11; out_idle_pct = 81; end
        1: begin in_idle_pct = 81; out_idle_pct = 11; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int i = 0; i < grbd_pkg::NUM_CFG; i++) begin
        case (step)
          0: setting[i] = '0;
          1: setting[i] = 4'd1;
          2: setting[i] = 4'd8;
          3: setting[i] = (i % 2) ? 4'd15 : 4'd0;  // out of range, clamped
          4: setting[i] = grbd_pkg::CFG_W'($urandom_range(0, 15));
          default: setting[i] = grbd_pkg::CFG_W'($urandom_range(1, 8));
        endcase
      end
      if (step == 0) begin
        // power-on widths, written back explicitly
        setting = '{4'd5, 4'd5, 4'd4, 4'd4, 4'd5, 4'd4, 4'd3};
      end
      write_cfg(setting);
      step_goal = items_sent + ITEMS_PER_STEP;

      if (step == 0) begin
        // bytes with no glyph open are dropped
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        send_glyph(31, 0, HDR_HIGH, GLYPH_PLAIN, 1'b0);
        send_glyph(0, 31, HDR_LOW, GLYPH_PLAIN, 1'b0);
        send_glyph(3, 2, HDR_RANDOM, GLYPH_EMPTY_RUN, 1'b0);
        send_glyph(12, 12, HDR_RANDOM, GLYPH_LONG_REPEAT, 1'b0);
        // restart mid-glyph
        put_byte(8'hA5, 1'b1);
        send_glyph(2, 2, HDR_RANDOM, GLYPH_PLAIN, 1'b0);
      end
      if (step == 2) begin
        // full 8-bit header extremes
        send_glyph(255, 0, HDR_HIGH, GLYPH_PLAIN, 1'b0);
        send_glyph(0, 255, HDR_LOW, GLYPH_PLAIN, 1'b0);
      end

      while (items_sent < step_goal) begin
        if ($urandom_range(99) < 10) begin
          // noise, possibly opening a garbage glyph
          repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 1'($urandom_range(1)));
        end else begin
          send_glyph(pick_size(), pick_size(), HDR_RANDOM,
                     ($urandom_range(99) < 10) ? GLYPH_EMPTY_RUN : GLYPH_PLAIN, 1'b1);
        end
      end
      in_if.valid <= 1'b0;
      wait_drained();
    end

    if (fail_count == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
